// ===== rtl/sfpa_pkg.sv =====
`timescale 1ns / 1ps
package sfpa_pkg;
    localparam int DATA_WIDTH_DEF = 64;
    localparam int PORT_WIDTH     = 64;
    localparam int CMD_WIDTH      = 3;

    localparam logic [CMD_WIDTH-1:0] CMD_ADD     = 3'd0;
    localparam logic [CMD_WIDTH-1:0] CMD_SUB     = 3'd1;
    localparam logic [CMD_WIDTH-1:0] CMD_NEG     = 3'd2;
    localparam logic [CMD_WIDTH-1:0] CMD_ABS     = 3'd3;
    localparam logic [CMD_WIDTH-1:0] CMD_SIGN    = 3'd4;
    localparam logic [CMD_WIDTH-1:0] CMD_MULDIV  = 3'd5;
    localparam logic [CMD_WIDTH-1:0] CMD_COMPARE = 3'd6;
endpackage

// ===== rtl/sfpa_div_cell.sv =====
`timescale 1ns / 1ps
// One restoring-division step of the pipelined quotient chain.
module sfpa_div_cell #(
    parameter int W = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           valid_in,
    input  logic [W-1:0]   rem_in,
    input  logic [2*W-1:0] num_in,
    input  logic [2*W-1:0] quo_in,
    input  logic [W-1:0]   den_in,
    input  logic           neg_in,
    input  logic           zero_in,
    output logic           valid_out,
    output logic [W-1:0]   rem_out,
    output logic [2*W-1:0] num_out,
    output logic [2*W-1:0] quo_out,
    output logic [W-1:0]   den_out,
    output logic           neg_out,
    output logic           zero_out
);
    logic [W:0]   trial;
    logic [W:0]   diff;
    logic         take;

    assign trial = {rem_in, num_in[2*W-1]};
    assign diff  = trial - {1'b0, den_in};
    assign take  = !diff[W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_out <= 1'b0;
        end
        else if (en)
        begin
            valid_out <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_out  <= take ? diff[W-1:0] : trial[W-1:0];
            num_out  <= {num_in[2*W-2:0], 1'b0};
            quo_out  <= {quo_in[2*W-2:0], take};
            den_out  <= den_in;
            neg_out  <= neg_in;
            zero_out <= zero_in;
        end
    end
endmodule

// ===== rtl/saturating_fixed_point_alu.sv =====
`timescale 1ns / 1ps
// All commands share one depth: stage 0, stage 1, the divider chain and the output register.
// Throughput: one transfer per cycle; the whole pipeline stalls only when the
// output register holds a result that is not taken.
// Reset clears all valid flags; payload registers are not reset.
module saturating_fixed_point_alu #(
    parameter int DATA_WIDTH = sfpa_pkg::DATA_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [sfpa_pkg::CMD_WIDTH-1:0]    command,
    input  logic signed [sfpa_pkg::PORT_WIDTH-1:0] operand_a,
    input  logic signed [sfpa_pkg::PORT_WIDTH-1:0] operand_b,
    input  logic signed [sfpa_pkg::PORT_WIDTH-1:0] divisor,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [sfpa_pkg::PORT_WIDTH-1:0] result,
    output logic                              less,
    output logic                              equal
);
    localparam int W = DATA_WIDTH;
    localparam int PW = sfpa_pkg::PORT_WIDTH;
    localparam int N = 2 * W;
    localparam int HW = W / 2;
    localparam int LW = W - HW;

    logic en;
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    logic signed [W-1:0] a, b, d;
    assign a = operand_a[W-1:0];
    assign b = operand_b[W-1:0];
    assign d = divisor[W-1:0];

    // stage 0: simple ops, magnitudes, partial products
    logic [W-1:0] ma, mb, md;
    assign ma = a[W-1] ? W'(-a) : W'(a);
    assign mb = b[W-1] ? W'(-b) : W'(b);
    assign md = d[W-1] ? W'(-d) : W'(d);

    logic signed [W:0] sum_x, sub_x, neg_x;
    assign sum_x = {a[W-1], a} + {b[W-1], b};
    assign sub_x = {a[W-1], a} - {b[W-1], b};
    assign neg_x = -{a[W-1], a};

    logic signed [W-1:0] maxv, minv;
    assign maxv = {1'b0, {(W-1){1'b1}}};
    assign minv = {1'b1, {(W-1){1'b0}}};

    function automatic logic signed [W-1:0] clampx(input logic signed [W:0] v,
        input logic signed [W-1:0] mx, input logic signed [W-1:0] mn);
        if (v[W] != v[W-1])
        begin
            return v[W] ? mn : mx;
        end
        return v[W-1:0];
    endfunction

    logic signed [W-1:0] simple_res;
    logic                simple_less, simple_eq;
    always_comb
    begin
        simple_res  = '0;
        simple_less = 1'b0;
        simple_eq   = 1'b0;
        unique case (command)
            sfpa_pkg::CMD_ADD: simple_res = clampx(sum_x, maxv, minv);
            sfpa_pkg::CMD_SUB: simple_res = clampx(sub_x, maxv, minv);
            sfpa_pkg::CMD_NEG: simple_res = clampx(neg_x, maxv, minv);
            sfpa_pkg::CMD_ABS: simple_res = a[W-1] ? clampx(neg_x, maxv, minv) : a;
            sfpa_pkg::CMD_SIGN:
                simple_res = a[W-1] ? '1 : ((a != '0) ? W'(1) : '0);
            sfpa_pkg::CMD_COMPARE:
            begin
                simple_less = a < b;
                simple_eq   = a == b;
            end
            default: simple_res = '0;
        endcase
    end

    logic           s0_valid_reg, s0_md_reg, s0_neg_reg, s0_zero_reg;
    logic [W-1:0]   s0_den_reg;
    logic [N-1:0]   pp00_reg, pp01_reg, pp10_reg, pp11_reg;
    logic signed [W-1:0] s0_res_reg;
    logic           s0_less_reg, s0_eq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_md_reg   <= command == sfpa_pkg::CMD_MULDIV;
            s0_neg_reg  <= (a[W-1] ^ b[W-1]) ^ d[W-1];
            s0_zero_reg <= d == '0;
            s0_den_reg  <= md;
            pp00_reg    <= N'(ma[LW-1:0] * mb[LW-1:0]);
            pp01_reg    <= N'(ma[LW-1:0] * mb[W-1:LW]) << LW;
            pp10_reg    <= N'(ma[W-1:LW] * mb[LW-1:0]) << LW;
            pp11_reg    <= N'(ma[W-1:LW] * mb[W-1:LW]) << (2 * LW);
            s0_res_reg  <= simple_res;
            s0_less_reg <= simple_less;
            s0_eq_reg   <= simple_eq;
        end
    end

    // stage 1: product sum
    logic           s1_valid_reg, s1_neg_reg, s1_zero_reg;
    logic [W-1:0]   s1_den_reg;
    logic [N-1:0]   s1_prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= s0_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_neg_reg  <= s0_neg_reg;
            s1_zero_reg <= s0_zero_reg;
            s1_den_reg  <= s0_den_reg;
            s1_prod_reg <= pp00_reg + pp01_reg + pp10_reg + pp11_reg;
        end
    end

    // side pipe for simple results, matched to the chain depth
    logic [N:0]              side_md;
    logic signed [W-1:0]     side_res  [N+1];
    logic                    side_less [N+1];
    logic                    side_eq   [N+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_md[0]   <= s0_md_reg;
            side_res[0]  <= s0_res_reg;
            side_less[0] <= s0_less_reg;
            side_eq[0]   <= s0_eq_reg;
            for (int i = 1; i <= N; i++)
            begin
                side_md[i]   <= side_md[i-1];
                side_res[i]  <= side_res[i-1];
                side_less[i] <= side_less[i-1];
                side_eq[i]   <= side_eq[i-1];
            end
        end
    end

    // division chain
    logic           c_valid [N+1];
    logic [W-1:0]   c_rem   [N+1];
    logic [N-1:0]   c_num   [N+1];
    logic [N-1:0]   c_quo   [N+1];
    logic [W-1:0]   c_den   [N+1];
    logic           c_neg   [N+1];
    logic           c_zero  [N+1];

    assign c_valid[0] = s1_valid_reg;
    assign c_rem[0]   = '0;
    assign c_num[0]   = s1_prod_reg;
    assign c_quo[0]   = '0;
    assign c_den[0]   = s1_den_reg;
    assign c_neg[0]   = s1_neg_reg;
    assign c_zero[0]  = s1_zero_reg;

    for (genvar g = 0; g < N; g++)
    begin : g_cell
        sfpa_div_cell #(.W(W)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .valid_in (c_valid[g]),
            .rem_in   (c_rem[g]),
            .num_in   (c_num[g]),
            .quo_in   (c_quo[g]),
            .den_in   (c_den[g]),
            .neg_in   (c_neg[g]),
            .zero_in  (c_zero[g]),
            .valid_out(c_valid[g+1]),
            .rem_out  (c_rem[g+1]),
            .num_out  (c_num[g+1]),
            .quo_out  (c_quo[g+1]),
            .den_out  (c_den[g+1]),
            .neg_out  (c_neg[g+1]),
            .zero_out (c_zero[g+1])
        );
    end

    // final saturation and output register
    logic [N-1:0]        q;
    logic signed [W-1:0] md_res;
    assign q = c_quo[N];
    always_comb
    begin
        priority if (c_zero[N])
            md_res = '0;
        else if (c_neg[N])
            md_res = (q > N'(unsigned'(minv))) ? minv : W'(-q[W-1:0]);
        else
            md_res = (q > N'(unsigned'(maxv))) ? maxv : q[W-1:0];
    end

    logic signed [W-1:0] res_reg;
    logic                out_valid_reg, less_reg, equal_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= c_valid[N];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg   <= side_md[N] ? md_res : side_res[N];
            less_reg  <= side_less[N];
            equal_reg <= side_eq[N];
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = PW'(res_reg);
    assign less      = less_reg;
    assign equal     = equal_reg;
endmodule

// ===== rtl/sfpa_checker.sv =====
`timescale 1ns / 1ps
module sfpa_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [63:0] result,
    input logic        less,
    input logic        equal
);
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("ready mismatch");
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (less || equal) |-> result == '0)
        else $error("flags with nonzero result");
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(less && equal))
        else $error("less and equal both set");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result))
        else $error("stalled result changed");
endmodule

bind saturating_fixed_point_alu sfpa_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_ready(in_ready), .out_valid(out_valid),
    .out_ready(out_ready), .result(result), .less(less), .equal(equal)
);
